>>> src/assert_macros.svh
// assertion helpers for the lcd bus sequencer
// used by the top level only, no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define CLBS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next
`define CLBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/clbs_pkg.sv
// shared types, codes and constants of the character lcd bus sequencer
// no dependencies
`timescale 1ns / 1ps

package clbs_pkg;

    // request codes
    localparam logic [1:0] CMD_IDLE   = 2'd0;
    localparam logic [1:0] CMD_INIT   = 2'd1;
    localparam logic [1:0] CMD_CHAR   = 2'd2;
    localparam logic [1:0] CMD_CURSOR = 2'd3;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;
    localparam logic [CFG_INDEX_W-1:0] CFG_STROBE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CMD_HOLD   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_HOLD  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_HOLD = 3'd4;

    // reset values of the timing registers
    localparam logic [7:0]  RST_STROBE     = 8'd42;
    localparam logic [15:0] RST_SETTLE     = 16'd1344;
    localparam logic [15:0] RST_CMD_HOLD   = 16'd6552;
    localparam logic [15:0] RST_DATA_HOLD  = 16'd7224;
    localparam logic [19:0] RST_CLEAR_HOLD = 20'd336000;

    // widest raw delay value before it goes into the timer
    localparam int LOAD_W = 20;

    localparam int BUSY_BIT     = 7;
    localparam logic [7:0] CLEAR_CMD    = 8'h01;
    localparam logic [7:0] SET_ADDR     = 8'h80;
    localparam logic [7:0] LINE2_OFFSET = 8'h40;
    localparam logic [1:0] LINE_TWO     = 2'd2;
    localparam logic [1:0] INIT_LEFT    = 2'd3;

    typedef struct packed {
        logic enable;
        logic select;
        logic read;
        logic drive;
    } t_pins;

    // init sequence byte still to send, by commands left after the current one
    function automatic logic [7:0] init_cmd(input logic [1:0] left);
        logic [7:0] b;
        case (left)
            2'd3: b = 8'h38;
            2'd2: b = 8'h0e;
            2'd1: b = 8'h04;
            default: b = CLEAR_CMD;
        endcase
        return b;
    endfunction

endpackage

>>> src/clbs_cfg.sv
// timing registers and the saturated timer load values derived from them
// depends on clbs_pkg
`timescale 1ns / 1ps

module clbs_cfg #(
    parameter int TIMER_BITS = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [clbs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [clbs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [TIMER_BITS-1:0]            o_poll_load,
    output logic [TIMER_BITS-1:0]            o_settle_load,
    output logic [TIMER_BITS-1:0]            o_strobe_load,
    output logic [TIMER_BITS-1:0]            o_cmd_hold_load,
    output logic [TIMER_BITS-1:0]            o_data_hold_load,
    output logic [TIMER_BITS-1:0]            o_clear_hold_load
);

    localparam logic [32:0] LIM = (33'd1 << TIMER_BITS) - 33'd1;

    logic [7:0]  r_strobe;
    logic [15:0] r_settle;
    logic [15:0] r_cmd_hold;
    logic [15:0] r_data_hold;
    logic [19:0] r_clear_hold;

    // zero is raised to one, too long saturates to the timer maximum
    function automatic logic [TIMER_BITS-1:0] f_load(input logic [clbs_pkg::LOAD_W-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        if (w == 33'd0) w = 33'd1;
        if (w > LIM) w = LIM;
        return w[TIMER_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe     <= clbs_pkg::RST_STROBE;
            r_settle     <= clbs_pkg::RST_SETTLE;
            r_cmd_hold   <= clbs_pkg::RST_CMD_HOLD;
            r_data_hold  <= clbs_pkg::RST_DATA_HOLD;
            r_clear_hold <= clbs_pkg::RST_CLEAR_HOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                clbs_pkg::CFG_STROBE:     r_strobe     <= i_cfg_data[7:0];
                clbs_pkg::CFG_SETTLE:     r_settle     <= i_cfg_data[15:0];
                clbs_pkg::CFG_CMD_HOLD:   r_cmd_hold   <= i_cfg_data[15:0];
                clbs_pkg::CFG_DATA_HOLD:  r_data_hold  <= i_cfg_data[15:0];
                clbs_pkg::CFG_CLEAR_HOLD: r_clear_hold <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // busy poll keeps e high for two strobe units
    assign o_poll_load       = f_load(clbs_pkg::LOAD_W'({r_strobe, 1'b0}));
    assign o_settle_load     = f_load(clbs_pkg::LOAD_W'(r_settle));
    assign o_strobe_load     = f_load(clbs_pkg::LOAD_W'(r_strobe));
    assign o_cmd_hold_load   = f_load(clbs_pkg::LOAD_W'(r_cmd_hold));
    assign o_data_hold_load  = f_load(clbs_pkg::LOAD_W'(r_data_hold));
    assign o_clear_hold_load = f_load(r_clear_hold);

endmodule

>>> src/clbs_seq.sv
// bus sequencer core: phase, timer, pending byte and the result register
// depends on clbs_pkg
`timescale 1ns / 1ps

module clbs_seq #(
    parameter int TIMER_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [1:0]            i_command,
    input  logic [7:0]            i_char_code,
    input  logic [5:0]            i_column,
    input  logic [1:0]            i_line,
    input  logic [7:0]            i_bus_in,
    input  logic [TIMER_BITS-1:0] i_poll_load,
    input  logic [TIMER_BITS-1:0] i_settle_load,
    input  logic [TIMER_BITS-1:0] i_strobe_load,
    input  logic [TIMER_BITS-1:0] i_cmd_hold_load,
    input  logic [TIMER_BITS-1:0] i_data_hold_load,
    input  logic [TIMER_BITS-1:0] i_clear_hold_load,
    output clbs_pkg::t_pins       o_pins,
    output logic [7:0]            o_data_out,
    output logic                  o_ready_res,
    output logic [7:0]            o_last_status
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_POLL,
        PH_GAP,
        PH_SETTLE,
        PH_STROBE,
        PH_HOLD
    } t_phase;

    t_phase                r_phase;
    logic [TIMER_BITS-1:0] r_timer;
    logic [7:0]            r_pending;
    logic                  r_is_data;
    logic [1:0]            r_init_left;
    logic [7:0]            r_status;

    clbs_pkg::t_pins       pins;
    logic                  idle;
    logic                  expired;
    logic [7:0]            cursor_addr;
    logic [TIMER_BITS-1:0] hold_load;

    always_comb begin
        idle = 1'b0;
        pins = '{enable: 1'b0, select: 1'b0, read: 1'b0, drive: 1'b1};
        case (r_phase)
            PH_POLL:   pins = '{enable: 1'b1, select: 1'b0, read: 1'b1, drive: 1'b0};
            PH_GAP:    pins = '{enable: 1'b0, select: 1'b0, read: 1'b1, drive: 1'b0};
            PH_SETTLE: pins = '{enable: 1'b0, select: r_is_data, read: 1'b0, drive: 1'b1};
            PH_STROBE: pins = '{enable: 1'b1, select: r_is_data, read: 1'b0, drive: 1'b1};
            PH_HOLD:   pins = '{enable: 1'b0, select: r_is_data, read: 1'b0, drive: 1'b1};
            default:   idle = 1'b1;
        endcase
    end

    assign expired = (r_timer <= TIMER_BITS'(1));

    // column is one-based; address wraps in eight bits
    always_comb begin
        cursor_addr = {2'b00, i_column} - 8'd1;
        if (i_line == clbs_pkg::LINE_TWO) cursor_addr = cursor_addr + clbs_pkg::LINE2_OFFSET;
    end

    always_comb begin
        if (r_is_data) hold_load = i_data_hold_load;
        else if (r_pending == clbs_pkg::CLEAR_CMD) hold_load = i_clear_hold_load;
        else hold_load = i_cmd_hold_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_pending   <= '0;
            r_is_data   <= 1'b0;
            r_init_left <= '0;
            r_status    <= '0;
        end else if (i_advance) begin
            // result shows the pins before this cycle's update
            o_pins        <= pins;
            o_data_out    <= pins.drive ? r_pending : 8'd0;
            o_ready_res   <= idle;
            o_last_status <= r_status;

            case (r_phase)
                PH_POLL: begin
                    if (!expired) begin
                        r_timer <= r_timer - TIMER_BITS'(1);
                    end else begin
                        r_status <= i_bus_in;
                        if (i_bus_in[clbs_pkg::BUSY_BIT]) begin
                            r_phase <= PH_GAP;
                            r_timer <= '0;
                        end else begin
                            r_phase <= PH_SETTLE;
                            r_timer <= i_settle_load;
                        end
                    end
                end
                PH_GAP: begin
                    r_phase <= PH_POLL;
                    r_timer <= i_poll_load;
                end
                PH_SETTLE: begin
                    if (!expired) begin
                        r_timer <= r_timer - TIMER_BITS'(1);
                    end else begin
                        r_phase <= PH_STROBE;
                        r_timer <= i_strobe_load;
                    end
                end
                PH_STROBE: begin
                    if (!expired) begin
                        r_timer <= r_timer - TIMER_BITS'(1);
                    end else begin
                        r_phase <= PH_HOLD;
                        r_timer <= hold_load;
                    end
                end
                PH_HOLD: begin
                    if (!expired) begin
                        r_timer <= r_timer - TIMER_BITS'(1);
                    end else if (r_init_left != 2'd0) begin
                        r_pending   <= clbs_pkg::init_cmd(r_init_left);
                        r_is_data   <= 1'b0;
                        r_init_left <= r_init_left - 2'd1;
                        r_phase     <= PH_POLL;
                        r_timer     <= i_poll_load;
                    end else begin
                        r_phase <= PH_IDLE;
                        r_timer <= '0;
                    end
                end
                default: begin
                    r_phase <= PH_IDLE;
                    case (i_command)
                        clbs_pkg::CMD_INIT: begin
                            r_pending   <= clbs_pkg::CLEAR_CMD;
                            r_is_data   <= 1'b0;
                            r_init_left <= clbs_pkg::INIT_LEFT;
                            r_phase     <= PH_POLL;
                            r_timer     <= i_poll_load;
                        end
                        clbs_pkg::CMD_CHAR: begin
                            r_pending   <= i_char_code;
                            r_is_data   <= 1'b1;
                            r_init_left <= 2'd0;
                            r_phase     <= PH_POLL;
                            r_timer     <= i_poll_load;
                        end
                        clbs_pkg::CMD_CURSOR: begin
                            r_pending   <= clbs_pkg::SET_ADDR | cursor_addr;
                            r_is_data   <= 1'b0;
                            r_init_left <= 2'd0;
                            r_phase     <= PH_POLL;
                            r_timer     <= i_poll_load;
                        end
                        default: ;
                    endcase
                end
            endcase
        end
    end

endmodule

>>> src/char_lcd_bus_sequencer.sv
// character lcd bus sequencer, top level: handshake and output register control
// depends on clbs_pkg, clbs_cfg, clbs_seq and assert_macros.svh
//
//   channel   direction   handshake                  payload
//   request   in          i_in_valid / o_in_stall    command, char_code, column, line, bus_in
//   pins      out         o_out_valid / i_out_stall  enable..last_status
//   config    in          i_cfg_we                   i_cfg_index, i_cfg_data
//
// one item per clock while the request side is not stalled: each accepted item is one tick of the bus sequencer
// the result of an item sits in the output register from the next cycle on
// request side stalls only while that register is full and the output is stalled
// synchronous active-low reset; the timing registers come up at their defaults
`timescale 1ns / 1ps
`include "assert_macros.svh"

module char_lcd_bus_sequencer #(
    parameter int TIMER_BITS = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [clbs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [clbs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_command,
    input  logic [7:0]                       i_char_code,
    input  logic [5:0]                       i_column,
    input  logic [1:0]                       i_line,
    input  logic [7:0]                       i_bus_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_enable_pin,
    output logic                             o_select_pin,
    output logic                             o_read_pin,
    output logic [7:0]                       o_data_out,
    output logic                             o_data_drive,
    output logic                             o_ready_res,
    output logic [7:0]                       o_last_status
);

    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  accept;
    clbs_pkg::t_pins       pins;
    logic [TIMER_BITS-1:0] poll_load;
    logic [TIMER_BITS-1:0] settle_load;
    logic [TIMER_BITS-1:0] strobe_load;
    logic [TIMER_BITS-1:0] cmd_hold_load;
    logic [TIMER_BITS-1:0] data_hold_load;
    logic [TIMER_BITS-1:0] clear_hold_load;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign n_out_valid = accept | (r_out_valid & i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    clbs_cfg #(
        .TIMER_BITS (TIMER_BITS)
    ) u_cfg (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_poll_load       (poll_load),
        .o_settle_load     (settle_load),
        .o_strobe_load     (strobe_load),
        .o_cmd_hold_load   (cmd_hold_load),
        .o_data_hold_load  (data_hold_load),
        .o_clear_hold_load (clear_hold_load)
    );

    clbs_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (accept),
        .i_command         (i_command),
        .i_char_code       (i_char_code),
        .i_column          (i_column),
        .i_line            (i_line),
        .i_bus_in          (i_bus_in),
        .i_poll_load       (poll_load),
        .i_settle_load     (settle_load),
        .i_strobe_load     (strobe_load),
        .i_cmd_hold_load   (cmd_hold_load),
        .i_data_hold_load  (data_hold_load),
        .i_clear_hold_load (clear_hold_load),
        .o_pins            (pins),
        .o_data_out        (o_data_out),
        .o_ready_res       (o_ready_res),
        .o_last_status     (o_last_status)
    );

    assign o_out_valid  = r_out_valid;
    assign o_enable_pin = pins.enable;
    assign o_select_pin = pins.select;
    assign o_read_pin   = pins.read;
    assign o_data_drive = pins.drive;

    `CLBS_ASSERT_ALWAYS(a_stall_needs_item, i_clk, i_rst_n, !o_in_stall || o_out_valid, "request stalled with no item held")
    `CLBS_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_out_valid, "accepted item not presented")
    `CLBS_ASSERT_ALWAYS(a_released_zero, i_clk, i_rst_n, !o_out_valid || o_data_drive || o_data_out == 8'd0, "data not zero while pins released")
    `CLBS_ASSERT_ALWAYS(a_released_reads, i_clk, i_rst_n, !o_out_valid || o_data_drive || o_read_pin, "pins released outside a read")

endmodule

>>> tb/sv/lcd_bus_checker.sv
// scoreboard for the character lcd bus sequencer: predicts the pins for each tick and checks them
// depends on clbs_pkg
`timescale 1ns / 1ps

module lcd_bus_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [clbs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [clbs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [1:0]                       i_command,
    input  logic [7:0]                       i_char_code,
    input  logic [5:0]                       i_column,
    input  logic [1:0]                       i_line,
    input  logic [7:0]                       i_bus_in,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic                             i_enable_pin,
    input  logic                             i_select_pin,
    input  logic                             i_read_pin,
    input  logic [7:0]                       i_data_out,
    input  logic                             i_data_drive,
    input  logic                             i_ready_res,
    input  logic [7:0]                       i_last_status,
    output int                               o_err_count,
    output int                               o_pending
);

    localparam int TMR_W = 20;
    localparam logic [TMR_W-1:0] TMR_MAX = '1;
    localparam logic [7:0] FUNC_SET_CMD   = 8'h38;
    localparam logic [7:0] DISPLAY_ON_CMD = 8'h0e;
    localparam logic [7:0] ENTRY_MODE_CMD = 8'h04;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_POLL,
        PH_GAP,
        PH_SETTLE,
        PH_STROBE,
        PH_HOLD
    } t_bus_phase;

    typedef struct packed {
        logic       enable;
        logic       select;
        logic       read;
        logic [7:0] data_out;
        logic       drive;
        logic       ready;
        logic [7:0] status;
    } t_pin_item;

    logic [7:0]  strobe_cfg;
    logic [15:0] settle_cfg;
    logic [15:0] cmd_hold_cfg;
    logic [15:0] data_hold_cfg;
    logic [19:0] clear_hold_cfg;

    t_bus_phase       phase;
    logic [TMR_W-1:0] delay_left;
    logic [7:0]       held_byte;
    logic             held_is_char;
    logic [1:0]       inits_left;
    logic [7:0]       status_seen;
    clbs_pkg::t_pins  pins;

    t_pin_item expected_pins[$];
    int        errors = 0;
    int        pending_n = 0;

    assign o_err_count = errors;
    assign o_pending   = pending_n;

    // zero is raised to one, anything past the timer range saturates
    function automatic logic [TMR_W-1:0] clamp_delay(input logic [31:0] cycles);
        if (cycles == 32'd0)
            return TMR_W'(1);
        if (cycles > 32'(TMR_MAX))
            return TMR_MAX;
        return cycles[TMR_W-1:0];
    endfunction

    function automatic void begin_poll();
        phase      = PH_POLL;
        delay_left = clamp_delay({23'd0, strobe_cfg, 1'b0});
    endfunction

    function automatic clbs_pkg::t_pins pins_of(input t_bus_phase ph, input logic is_char);
        clbs_pkg::t_pins p;
        p = '0;
        case (ph)
            PH_POLL: begin
                p.enable = 1'b1;
                p.read   = 1'b1;
            end
            PH_GAP: begin
                p.read = 1'b1;
            end
            PH_SETTLE, PH_HOLD: begin
                p.drive  = 1'b1;
                p.select = is_char;
            end
            PH_STROBE: begin
                p.enable = 1'b1;
                p.drive  = 1'b1;
                p.select = is_char;
            end
            default: begin
                p.drive = 1'b1;
            end
        endcase
        return p;
    endfunction

    // one clock tick of the sequencer: pins as they stand, then the state update
    function automatic t_pin_item tick_lcd_bus(input logic [1:0] cmd, input logic [7:0] chr,
                                               input logic [5:0] col, input logic [1:0] ln,
                                               input logic [7:0] bus);
        t_pin_item   r;
        logic [7:0]  addr;
        logic [31:0] hold;
        r.enable   = pins.enable;
        r.select   = pins.select;
        r.read     = pins.read;
        r.data_out = pins.drive ? held_byte : 8'h00;
        r.drive    = pins.drive;
        r.ready    = (phase == PH_IDLE);
        r.status   = status_seen;

        if (phase == PH_IDLE) begin
            case (cmd)
                clbs_pkg::CMD_INIT: begin
                    held_byte    = clbs_pkg::CLEAR_CMD;
                    held_is_char = 1'b0;
                    inits_left   = 2'd3;
                    begin_poll();
                end
                clbs_pkg::CMD_CHAR: begin
                    held_byte    = chr;
                    held_is_char = 1'b1;
                    inits_left   = 2'd0;
                    begin_poll();
                end
                clbs_pkg::CMD_CURSOR: begin
                    // column zero wraps in eight bits
                    addr = {2'b00, col} - 8'd1;
                    if (ln == clbs_pkg::LINE_TWO)
                        addr = addr + clbs_pkg::LINE2_OFFSET;
                    held_byte    = clbs_pkg::SET_ADDR | addr;
                    held_is_char = 1'b0;
                    inits_left   = 2'd0;
                    begin_poll();
                end
                default: ;
            endcase
        end else if (phase == PH_GAP) begin
            begin_poll();
        end else if (delay_left > TMR_W'(1)) begin
            delay_left = delay_left - TMR_W'(1);
        end else if (phase == PH_POLL) begin
            status_seen = bus;
            if (bus[clbs_pkg::BUSY_BIT]) begin
                phase      = PH_GAP;
                delay_left = '0;
            end else begin
                phase      = PH_SETTLE;
                delay_left = clamp_delay(32'(settle_cfg));
            end
        end else if (phase == PH_SETTLE) begin
            phase      = PH_STROBE;
            delay_left = clamp_delay(32'(strobe_cfg));
        end else if (phase == PH_STROBE) begin
            if (held_is_char)
                hold = 32'(data_hold_cfg);
            else if (held_byte == clbs_pkg::CLEAR_CMD)
                hold = 32'(clear_hold_cfg);
            else
                hold = 32'(cmd_hold_cfg);
            phase      = PH_HOLD;
            delay_left = clamp_delay(hold);
        end else if (inits_left != 2'd0) begin
            case (inits_left)
                2'd3:    held_byte = FUNC_SET_CMD;
                2'd2:    held_byte = DISPLAY_ON_CMD;
                default: held_byte = ENTRY_MODE_CMD;
            endcase
            held_is_char = 1'b0;
            inits_left   = inits_left - 2'd1;
            begin_poll();
        end else begin
            phase      = PH_IDLE;
            delay_left = '0;
        end

        pins = pins_of(phase, held_is_char);
        return r;
    endfunction

    task automatic check_pin(input string name, input logic [7:0] want_v, input logic [7:0] got_v);
        if (want_v !== got_v) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_pin_item want;
        if (!i_rst_n) begin
            strobe_cfg     = clbs_pkg::RST_STROBE;
            settle_cfg     = clbs_pkg::RST_SETTLE;
            cmd_hold_cfg   = clbs_pkg::RST_CMD_HOLD;
            data_hold_cfg  = clbs_pkg::RST_DATA_HOLD;
            clear_hold_cfg = clbs_pkg::RST_CLEAR_HOLD;
            phase          = PH_IDLE;
            delay_left     = '0;
            held_byte      = 8'h00;
            held_is_char   = 1'b0;
            inits_left     = 2'd0;
            status_seen    = 8'h00;
            pins           = pins_of(PH_IDLE, 1'b0);
            expected_pins.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    clbs_pkg::CFG_STROBE:     strobe_cfg     = i_cfg_data[7:0];
                    clbs_pkg::CFG_SETTLE:     settle_cfg     = i_cfg_data[15:0];
                    clbs_pkg::CFG_CMD_HOLD:   cmd_hold_cfg   = i_cfg_data[15:0];
                    clbs_pkg::CFG_DATA_HOLD:  data_hold_cfg  = i_cfg_data[15:0];
                    clbs_pkg::CFG_CLEAR_HOLD: clear_hold_cfg = i_cfg_data[19:0];
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (expected_pins.size() == 0) begin
                    errors++;
                    $display({"%0t: item expected none, got e%0b rs%0b rw%0b d%0h",
                              " drv%0b rdy%0b st%0h"},
                             $time, i_enable_pin, i_select_pin, i_read_pin, i_data_out,
                             i_data_drive, i_ready_res, i_last_status);
                end else begin
                    want = expected_pins.pop_front();
                    check_pin("enable_pin", 8'(want.enable), 8'(i_enable_pin));
                    check_pin("select_pin", 8'(want.select), 8'(i_select_pin));
                    check_pin("read_pin", 8'(want.read), 8'(i_read_pin));
                    check_pin("data_out", want.data_out, i_data_out);
                    check_pin("data_drive", 8'(want.drive), 8'(i_data_drive));
                    check_pin("ready_res", 8'(want.ready), 8'(i_ready_res));
                    check_pin("last_status", want.status, i_last_status);
                end
            end

            if (i_in_valid && !i_in_stall)
                expected_pins.push_back(tick_lcd_bus(i_command, i_char_code, i_column,
                                                     i_line, i_bus_in));
        end
        pending_n = expected_pins.size();
    end

endmodule

>>> tb/sv/tb_char_lcd_bus_sequencer.sv
// testbench top for the character lcd bus sequencer: clock, reset, timing writes and requests
// depends on clbs_pkg, char_lcd_bus_sequencer and lcd_bus_checker
`timescale 1ns / 1ps

module tb_char_lcd_bus_sequencer;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 8;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int EXTREME_ITEMS   = 100;
    localparam int BUSY_PCT        = 25;
    localparam logic [clbs_pkg::CFG_INDEX_W-1:0] CFG_INDEX_TOP = '1;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [clbs_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [clbs_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                             i_in_valid;
    logic                             o_in_stall;
    logic [1:0]                       i_command;
    logic [7:0]                       i_char_code;
    logic [5:0]                       i_column;
    logic [1:0]                       i_line;
    logic [7:0]                       i_bus_in;
    logic                             o_out_valid;
    logic                             i_out_stall;
    logic                             o_enable_pin;
    logic                             o_select_pin;
    logic                             o_read_pin;
    logic [7:0]                       o_data_out;
    logic                             o_data_drive;
    logic                             o_ready_res;
    logic [7:0]                       o_last_status;

    int err_count;
    int pending_count;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    char_lcd_bus_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_char_code   (i_char_code),
        .i_column      (i_column),
        .i_line        (i_line),
        .i_bus_in      (i_bus_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_enable_pin  (o_enable_pin),
        .o_select_pin  (o_select_pin),
        .o_read_pin    (o_read_pin),
        .o_data_out    (o_data_out),
        .o_data_drive  (o_data_drive),
        .o_ready_res   (o_ready_res),
        .o_last_status (o_last_status)
    );

    lcd_bus_checker u_lcd_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_char_code   (i_char_code),
        .i_column      (i_column),
        .i_line        (i_line),
        .i_bus_in      (i_bus_in),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_enable_pin  (o_enable_pin),
        .i_select_pin  (o_select_pin),
        .i_read_pin    (o_read_pin),
        .i_data_out    (o_data_out),
        .i_data_drive  (o_data_drive),
        .i_ready_res   (o_ready_res),
        .i_last_status (o_last_status),
        .o_err_count   (err_count),
        .o_pending     (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_char_lcd_bus_sequencer: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_request(input logic [1:0] cmd, input logic [7:0] chr,
                                input logic [5:0] col, input logic [1:0] ln,
                                input logic [7:0] bus);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_char_code <= chr;
        i_column    <= col;
        i_line      <= ln;
        i_bus_in    <= bus;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // mostly idle ticks so that requests land while the bus is both free and busy
    task automatic push_random_item();
        int         pick;
        logic [1:0] cmd;
        logic [5:0] col;
        logic [1:0] ln;
        logic [7:0] bus;
        pick = $urandom_range(99);
        if (pick < 55)
            cmd = clbs_pkg::CMD_IDLE;
        else if (pick < 65)
            cmd = clbs_pkg::CMD_INIT;
        else if (pick < 82)
            cmd = clbs_pkg::CMD_CHAR;
        else
            cmd = clbs_pkg::CMD_CURSOR;
        col = ($urandom_range(99) < 80) ? 6'($urandom_range(40, 1)) : 6'($urandom_range(63, 0));
        ln  = ($urandom_range(99) < 85) ? 2'($urandom_range(2, 1)) : 2'($urandom_range(3, 0));
        bus = 8'($urandom);
        bus[clbs_pkg::BUSY_BIT] = ($urandom_range(99) < BUSY_PCT);
        push_request(cmd, 8'($urandom), col, ln, bus);
    endtask

    task automatic write_timing(input logic [clbs_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [clbs_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
    endtask

    // dirty puts random bits above the width of each register narrower than the data, which must be dropped
    task automatic set_timing(input logic [7:0] strobe, input logic [15:0] settle,
                              input logic [15:0] cmd_hold, input logic [15:0] data_hold,
                              input logic [19:0] clear_hold, input logic dirty);
        logic [31:0] junk;
        junk = dirty ? $urandom : 32'd0;
        write_timing(clbs_pkg::CFG_STROBE, {junk[11:0], strobe});
        write_timing(clbs_pkg::CFG_SETTLE, {junk[15:12], settle});
        write_timing(clbs_pkg::CFG_CMD_HOLD, {junk[19:16], cmd_hold});
        write_timing(clbs_pkg::CFG_DATA_HOLD, {junk[23:20], data_hold});
        write_timing(clbs_pkg::CFG_CLEAR_HOLD, clear_hold);
        for (int k = int'(clbs_pkg::CFG_CLEAR_HOLD) + 1; k <= int'(CFG_INDEX_TOP); k++)
            write_timing(clbs_pkg::CFG_INDEX_W'(k), clbs_pkg::CFG_DATA_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
    endtask

    initial begin
        logic [7:0] busy_bus;
        int         n_items;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_command   = clbs_pkg::CMD_IDLE;
        i_char_code = 8'h00;
        i_column    = 6'd0;
        i_line      = 2'd0;
        i_bus_in    = 8'h00;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default strobe length: a character write keeps polling a busy display
        push_request(clbs_pkg::CMD_CHAR, 8'($urandom), 6'($urandom), 2'($urandom), 8'h00);
        repeat (95) begin
            busy_bus = 8'($urandom);
            busy_bus[clbs_pkg::BUSY_BIT] = 1'b1;
            push_request(clbs_pkg::CMD_IDLE, 8'($urandom), 6'($urandom), 2'($urandom),
                         busy_bus);
        end

        // all timing at zero, so every wait gets the smallest timer load
        drain_results();
        set_timing(8'd0, 16'd0, 16'd0, 16'd0, 20'd0, 1'b0);
        push_request(clbs_pkg::CMD_CURSOR, 8'h5a, 6'd0, clbs_pkg::LINE_TWO, 8'h00);
        // display busy; the character request arrives mid-poll and is dropped
        push_request(clbs_pkg::CMD_CHAR, 8'ha5, 6'd5, 2'd1, 8'hff);
        push_request(clbs_pkg::CMD_INIT, 8'h00, 6'd0, 2'd0, 8'h00);
        push_request(clbs_pkg::CMD_IDLE, 8'h00, 6'd0, 2'd0, 8'h7f);
        repeat (3) push_request(clbs_pkg::CMD_IDLE, 8'h00, 6'd0, 2'd0, 8'h00);
        push_request(clbs_pkg::CMD_CHAR, 8'hff, 6'd63, 2'd3, 8'h00);
        repeat (4) push_request(clbs_pkg::CMD_IDLE, 8'h00, 6'd0, 2'd0, 8'h00);
        push_request(clbs_pkg::CMD_CHAR, 8'h00, 6'd0, 2'd0, 8'h00);
        push_request(clbs_pkg::CMD_IDLE, 8'h00, 6'd0, 2'd0, 8'h80);
        repeat (4) push_request(clbs_pkg::CMD_IDLE, 8'h00, 6'd0, 2'd0, 8'h00);
        push_request(clbs_pkg::CMD_CURSOR, 8'h00, 6'd40, 2'd1, 8'h00);
        repeat (4) push_request(clbs_pkg::CMD_IDLE, 8'h00, 6'd0, 2'd0, 8'h00);
        push_request(clbs_pkg::CMD_INIT, 8'h00, 6'd0, 2'd0, 8'h00);
        repeat (2) push_request(clbs_pkg::CMD_IDLE, 8'h00, 6'd0, 2'd0, 8'h00);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            case (p)
                0: set_timing(8'd1, 16'd1, 16'd1, 16'd1, 20'd1, 1'b0);
                3: set_timing(8'($urandom_range(20, 4)), 16'($urandom_range(40, 4)),
                              16'($urandom_range(60, 4)), 16'($urandom_range(60, 4)),
                              20'($urandom_range(100, 4)), 1'b1);
                // saturated timing last, the block then sits in long waits
                RANDOM_PHASES - 1: set_timing(8'hff, 16'hffff, 16'hffff, 16'hffff, 20'hfffff,
                                              1'b0);
                default: set_timing(8'($urandom_range(3, 0)), 16'($urandom_range(6, 0)),
                                    16'($urandom_range(6, 0)), 16'($urandom_range(6, 0)),
                                    20'($urandom_range(12, 0)), 1'b1);
            endcase
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 67;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 67;
                end
                default: begin
                    send_idle_pct = 21;
                    stall_pct     = 21;
                end
            endcase
            n_items = (p == RANDOM_PHASES - 1) ? EXTREME_ITEMS : ITEMS_PER_PHASE;
            repeat (n_items) push_random_item();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_count == 0) begin
            $display("tb_char_lcd_bus_sequencer: done, clean");
        end else begin
            $display("tb_char_lcd_bus_sequencer: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/clbs_pkg.sv
src/clbs_cfg.sv
src/clbs_seq.sv
src/char_lcd_bus_sequencer.sv
tb/sv/lcd_bus_checker.sv
tb/sv/tb_char_lcd_bus_sequencer.sv
